FILE: rtl/mvmp_pkg.sv
// ----------------------------------------------------------------------------
// mvmp_pkg
// Shared widths, command codes, beat types and modular add for the
// vector-matrix power unit.
// ----------------------------------------------------------------------------
package mvmp_pkg;

    localparam int DEF_SIZE = 11;
    localparam int VAL_W    = 62;
    localparam int WORD_W   = 63;
    localparam int IDX_W    = 4;
    localparam int STEPS    = WORD_W;

    localparam logic [WORD_W-1:0] MOD_RESET = 63'd1000000007;

    localparam logic [1:0] CMD_MAT = 2'd0;
    localparam logic [1:0] CMD_VEC = 2'd1;
    localparam logic [1:0] CMD_RUN = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [VAL_W-1:0]  value;
        logic [WORD_W-1:0] exponent;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] result_value;
        logic             last;
    } t_out_item;

    // one doubling step travelling down the cell row
    typedef struct packed {
        logic              vld;
        logic [WORD_W-1:0] x;
    } t_link;

    // a, b below m
    function automatic logic [WORD_W-1:0] add_mod(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b,
                                                  input logic [WORD_W-1:0] m);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[WORD_W-1:0];
    endfunction

endpackage

FILE: rtl/mvmp_cell.sv
// ----------------------------------------------------------------------------
// mvmp_cell
// One column cell: holds the multiplier bits of its column and a running
// modular sum, consumes one doubled operand per beat and forwards it.
// ----------------------------------------------------------------------------
module mvmp_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [mvmp_pkg::WORD_W-1:0]     i_mod,
    input  logic                            i_clr,
    input  logic                            i_load,
    input  logic [mvmp_pkg::WORD_W-1:0]     i_y,
    input  mvmp_pkg::t_link                 i_link,
    output mvmp_pkg::t_link                 o_link,
    output logic [mvmp_pkg::WORD_W-1:0]     o_acc
);
    import mvmp_pkg::*;

    logic [WORD_W-1:0] r_y;
    logic [WORD_W-1:0] r_acc;
    t_link             r_link;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.vld <= 1'b0;
        end else begin
            r_link.vld <= i_link.vld;
        end
        r_link.x <= i_link.x;
        if (i_load) begin
            r_y <= i_y;
        end else if (i_link.vld) begin
            r_y <= r_y >> 1;
        end
        if (i_clr) begin
            r_acc <= '0;
        end else if (i_link.vld && r_y[0]) begin
            r_acc <= add_mod(r_acc, i_link.x, i_mod);
        end
    end

    assign o_link = r_link;
    assign o_acc  = r_acc;

endmodule

FILE: rtl/mvmp_rem_unit.sv
// ----------------------------------------------------------------------------
// mvmp_rem_unit
// Restoring remainder unit: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mvmp_rem_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mvmp_pkg::WORD_W-1:0] i_num,
    input  logic [mvmp_pkg::WORD_W-1:0] i_mod,
    output logic                        o_done,
    output logic [mvmp_pkg::WORD_W-1:0] o_rem
);
    import mvmp_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_num;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;

    assign trial = {r_rem, r_num[WORD_W-1]};
    assign diff  = trial - {1'b0, i_mod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= (trial >= {1'b0, i_mod}) ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/modular_vector_matrix_power_unit.sv
// ----------------------------------------------------------------------------
// modular_vector_matrix_power_unit
// Row vector times matrix power, modulo a programmable modulus.
// ----------------------------------------------------------------------------
// Commands come in on start/i_item and are taken when busy is low.
// cmd 0 stores a matrix entry, cmd 1 a vector entry; each is reduced by the
// remainder unit, and busy stays high until the reduced entry is stored.
// cmd 2 runs square-and-multiply over the exponent, LSB first. Every product
// term goes through a row of SIZE column cells: a head stage doubles the
// row operand once per multiplier bit and the cells add it where their
// multiplier bit is set. A vector pass is SIZE terms, a squaring pass
// SIZE*SIZE terms. A run first reduces the vector and the matrix
// (SIZE*(SIZE+1) remainders), then spends one vector pass per set exponent
// bit and one squaring pass per bit below the top one. The result is then
// shown as SIZE beats, one per cycle, on o_strobe/o_result with last on the
// final beat; it also becomes the vector.
// The receiver cannot stall; beats go out unconditionally. Reset clears the
// matrix and vector (per-entry valid flags) and loads the modulus register
// with 1000000007; the block is ready right after reset. The user writes the
// modulus via i_cfg_we/i_cfg_wdata only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module modular_vector_matrix_power_unit #(
    parameter int SIZE = mvmp_pkg::DEF_SIZE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  mvmp_pkg::t_in_item          i_item,
    output logic                        busy,
    output logic                        o_strobe,
    output mvmp_pkg::t_out_item         o_result,
    input  logic                        i_cfg_we,
    input  logic [mvmp_pkg::WORD_W-1:0] i_cfg_wdata
);
    import mvmp_pkg::*;

    localparam int IW   = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int HC_W = $clog2(STEPS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LD_WAIT, S_RV_GO, S_RV_WAIT, S_RM_RD, S_RM_GO, S_RM_WAIT,
        S_CHK, S_TERM_RD, S_TERM_LD, S_TERM_RUN, S_ROW_WR, S_EMIT
    } t_state;

    t_state            r_state;
    logic [WORD_W-1:0] r_mod;
    logic [WORD_W-1:0] m_eff;
    logic              r_ld_mat;
    logic [IW-1:0]     r_row;
    logic [IW-1:0]     r_col;
    logic [WORD_W-1:0] r_e;
    logic [IW-1:0]     r_i;
    logic [IW-1:0]     r_k;
    logic [IW-1:0]     r_c;
    logic              r_vec_mode;
    logic              r_sel;
    logic [HC_W-1:0]   r_tcnt;
    logic [HC_W-1:0]   r_hcnt;
    logic              r_hact;
    logic [WORD_W-1:0] r_x;
    t_link             r_hl;
    logic              r_stb;
    t_out_item         r_out;

    logic [SIZE-1:0][VAL_W-1:0]  r_tm [SIZE];
    logic [SIZE-1:0]             r_tm_vld [SIZE];
    logic [SIZE-1:0][WORD_W-1:0] r_bs0 [SIZE];
    logic [SIZE-1:0][WORD_W-1:0] r_bs1 [SIZE];
    logic [WORD_W-1:0]           r_vec [SIZE];

    logic [SIZE-1:0][VAL_W-1:0]  r_tm_rd;
    logic [SIZE-1:0][WORD_W-1:0] r_a0, r_a1, r_b0, r_b1;
    logic [SIZE-1:0][WORD_W-1:0] rd_a, rd_b;
    logic [SIZE-1:0][WORD_W-1:0] acc_row;
    t_link                       links [SIZE+1];

    logic              load_ok;
    logic              div_start;
    logic [WORD_W-1:0] div_num;
    logic              div_done;
    logic [WORD_W-1:0] div_rem;
    logic [WORD_W-1:0] tm_entry;
    logic [WORD_W-1:0] x_op;
    logic              cell_load;
    logic              cell_clr;

    assign m_eff = (r_mod == '0) ? WORD_W'(1) : r_mod;

    always_comb begin
        load_ok = 1'b0;
        if (i_item.cmd == CMD_MAT) begin
            load_ok = (32'(i_item.row) < SIZE) && (32'(i_item.col) < SIZE);
        end else if (i_item.cmd == CMD_VEC) begin
            load_ok = 32'(i_item.col) < SIZE;
        end
    end

    assign tm_entry = r_tm_vld[r_i][r_c] ? {1'b0, r_tm_rd[r_c]} : '0;

    always_comb begin
        div_start = 1'b0;
        div_num   = {1'b0, i_item.value};
        if (r_state == S_IDLE) begin
            div_start = start && load_ok;
        end else if (r_state == S_RV_GO) begin
            div_start = 1'b1;
            div_num   = r_vec[r_c];
        end else if (r_state == S_RM_GO) begin
            div_start = 1'b1;
            div_num   = tm_entry;
        end
    end

    mvmp_rem_unit u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_mod   (m_eff),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    // memories: registered reads at the current row addresses
    always_ff @(posedge i_clk) begin
        r_tm_rd <= r_tm[r_i];
        r_a0    <= r_bs0[r_i];
        r_a1    <= r_bs1[r_i];
        r_b0    <= r_bs0[r_k];
        r_b1    <= r_bs1[r_k];
        if (r_state == S_LD_WAIT && div_done && r_ld_mat) begin
            r_tm[r_row][r_col] <= div_rem[VAL_W-1:0];
        end
        if (r_state == S_RM_WAIT && div_done) begin
            r_bs0[r_i][r_c] <= div_rem;
        end else if (r_state == S_ROW_WR && !r_vec_mode && r_sel) begin
            r_bs0[r_i] <= acc_row;
        end
        if (r_state == S_ROW_WR && !r_vec_mode && !r_sel) begin
            r_bs1[r_i] <= acc_row;
        end
    end

    assign rd_a = r_sel ? r_a1 : r_a0;
    assign rd_b = r_sel ? r_b1 : r_b0;
    assign x_op = r_vec_mode ? r_vec[r_k] : rd_a[r_k];

    assign cell_load = (r_state == S_TERM_LD);
    assign cell_clr  = (r_state == S_TERM_LD) && (r_k == '0);

    // head stage: emit x, 2x, 4x, ... mod m, one beat per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hact  <= 1'b0;
            r_hcnt  <= '0;
            r_hl.vld <= 1'b0;
        end else begin
            r_hl.vld <= r_hact;
            if (r_state == S_TERM_LD) begin
                r_hact <= 1'b1;
                r_hcnt <= '0;
            end else if (r_hact) begin
                r_hcnt <= r_hcnt + 1'b1;
                if (r_hcnt == HC_W'(STEPS - 1)) begin
                    r_hact <= 1'b0;
                end
            end
        end
        r_hl.x <= r_x;
        if (r_state == S_TERM_LD) begin
            r_x <= x_op;
        end else if (r_hact) begin
            r_x <= add_mod(r_x, r_x, m_eff);
        end
    end

    assign links[0] = r_hl;

    for (genvar j = 0; j < SIZE; j++) begin : g_cell
        mvmp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_mod   (m_eff),
            .i_clr   (cell_clr),
            .i_load  (cell_load),
            .i_y     (rd_b[j]),
            .i_link  (links[j]),
            .o_link  (links[j+1]),
            .o_acc   (acc_row[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mod      <= MOD_RESET;
            r_stb      <= 1'b0;
            r_sel      <= 1'b0;
            r_vec_mode <= 1'b0;
            r_c        <= '0;
            r_i        <= '0;
            r_k        <= '0;
            for (int n = 0; n < SIZE; n++) begin
                r_vec[n]    <= '0;
                r_tm_vld[n] <= '0;
            end
        end else begin
            r_stb <= 1'b0;
            if (i_cfg_we) begin
                r_mod <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_row    <= i_item.row[IW-1:0];
                        r_col    <= i_item.col[IW-1:0];
                        r_ld_mat <= (i_item.cmd == CMD_MAT);
                        if (load_ok) begin
                            r_state <= S_LD_WAIT;
                        end else if (i_item.cmd == CMD_RUN) begin
                            r_e     <= i_item.exponent;
                            r_c     <= '0;
                            r_sel   <= 1'b0;
                            r_state <= S_RV_GO;
                        end
                    end
                end
                S_LD_WAIT: begin
                    if (div_done) begin
                        if (r_ld_mat) begin
                            r_tm_vld[r_row][r_col] <= 1'b1;
                        end else begin
                            r_vec[r_col] <= div_rem;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_RV_GO: r_state <= S_RV_WAIT;
                S_RV_WAIT: begin
                    if (div_done) begin
                        r_vec[r_c] <= div_rem;
                        if (r_c == IW'(SIZE - 1)) begin
                            r_c     <= '0;
                            r_i     <= '0;
                            r_state <= S_RM_RD;
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_RV_GO;
                        end
                    end
                end
                S_RM_RD: r_state <= S_RM_GO;
                S_RM_GO: r_state <= S_RM_WAIT;
                S_RM_WAIT: begin
                    if (div_done) begin
                        if (r_c == IW'(SIZE - 1)) begin
                            r_c <= '0;
                            if (r_i == IW'(SIZE - 1)) begin
                                r_state <= S_CHK;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_RM_RD;
                            end
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_RM_GO;
                        end
                    end
                end
                S_CHK: begin
                    r_i <= '0;
                    r_k <= '0;
                    r_c <= '0;
                    if (r_e == '0) begin
                        r_state <= S_EMIT;
                    end else if (r_e[0]) begin
                        r_vec_mode <= 1'b1;
                        r_state    <= S_TERM_RD;
                    end else begin
                        // drop the low bit, square unless nothing is left
                        r_e <= r_e >> 1;
                        if (r_e[WORD_W-1:1] == '0) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_vec_mode <= 1'b0;
                            r_state    <= S_TERM_RD;
                        end
                    end
                end
                S_TERM_RD: r_state <= S_TERM_LD;
                S_TERM_LD: begin
                    r_tcnt  <= '0;
                    r_state <= S_TERM_RUN;
                end
                S_TERM_RUN: begin
                    // the last cell has used a beat once it shows at the tail
                    if (links[SIZE].vld) begin
                        r_tcnt <= r_tcnt + 1'b1;
                        if (r_tcnt == HC_W'(STEPS - 1)) begin
                            if (r_k == IW'(SIZE - 1)) begin
                                r_state <= S_ROW_WR;
                            end else begin
                                r_k     <= r_k + 1'b1;
                                r_state <= S_TERM_RD;
                            end
                        end
                    end
                end
                S_ROW_WR: begin
                    r_k <= '0;
                    if (r_vec_mode) begin
                        for (int n = 0; n < SIZE; n++) begin
                            r_vec[n] <= acc_row[n];
                        end
                        r_e[0]  <= 1'b0;
                        r_state <= S_CHK;
                    end else if (r_i == IW'(SIZE - 1)) begin
                        r_sel   <= ~r_sel;
                        r_state <= S_CHK;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_TERM_RD;
                    end
                end
                S_EMIT: begin
                    r_stb              <= 1'b1;
                    r_out.index        <= IDX_W'(r_c);
                    r_out.result_value <= r_vec[r_c][VAL_W-1:0];
                    r_out.last         <= (r_c == IW'(SIZE - 1));
                    if (r_c == IW'(SIZE - 1)) begin
                        r_c     <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_stb;
    assign o_result = r_out;

endmodule

FILE: verif/modular_vector_matrix_power_unit_test.sv
// ----------------------------------------------------------------------------
// modular_vector_matrix_power_unit_test
// Self-checking bench for the vector-matrix power unit: a directed table of
// loads, runs and modulus writes, then random phases of loads, noise and
// short runs under varying sender gaps, all scored against a local predictor.
// ----------------------------------------------------------------------------
module modular_vector_matrix_power_unit_test;
    import mvmp_pkg::*;

    localparam int N       = DEF_SIZE;
    localparam int CELLS   = N * N;
    localparam int WD_MAX  = 3000000;
    localparam int SETTLE  = 100;

    typedef enum logic [1:0] { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  cmd;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [61:0] value;
        logic [62:0] exponent;
        bit          want_zero;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_in_item    i_item;
    logic        busy;
    logic        o_strobe;
    t_out_item   o_result;
    logic        i_cfg_we;
    logic [62:0] i_cfg_wdata;

    modular_vector_matrix_power_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_item      (i_item),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // predictor state
    logic [63:0] pm_mod;
    logic [63:0] pm_mat [CELLS];
    logic [63:0] pm_vec [N];

    t_out_item   exp_beats[$];
    int          errors;
    int          idle_pct;
    int          stall_cnt;

    function automatic logic [63:0] live_mod();
        return (pm_mod == 64'd0) ? 64'd1 : pm_mod;
    endfunction

    function automatic logic [63:0] mod_sum(logic [63:0] x, logic [63:0] y,
                                            logic [63:0] m);
        logic [63:0] s;
        s = x + y;
        return (s >= m) ? s - m : s;
    endfunction

    function automatic logic [63:0] mod_prod(logic [63:0] x, logic [63:0] y,
                                             logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd0;
        x = x % m;
        y = y % m;
        while (y != 64'd0) begin
            if (y[0]) begin
                acc = mod_sum(acc, x, m);
            end
            x = mod_sum(x, x, m);
            y = y >> 1;
        end
        return acc;
    endfunction

    // square-and-multiply, LSB first; queue one beat per vector entry
    task automatic predict_power(logic [62:0] e, bit want_zero);
        logic [63:0] m;
        logic [63:0] base [CELLS];
        logic [63:0] sq   [CELLS];
        logic [63:0] tmp  [N];
        logic [63:0] s;
        t_out_item   b;
        m = live_mod();
        for (int i = 0; i < N; i++) pm_vec[i] = pm_vec[i] % m;
        for (int i = 0; i < CELLS; i++) base[i] = pm_mat[i];
        while (e != 63'd0) begin
            if (e[0]) begin
                for (int j = 0; j < N; j++) begin
                    s = 64'd0;
                    for (int k = 0; k < N; k++)
                        s = mod_sum(s, mod_prod(pm_vec[k], base[k*N+j], m), m);
                    tmp[j] = s;
                end
                for (int j = 0; j < N; j++) pm_vec[j] = tmp[j];
            end
            e = e >> 1;
            if (e != 63'd0) begin
                for (int i = 0; i < N; i++) begin
                    for (int j = 0; j < N; j++) begin
                        s = 64'd0;
                        for (int k = 0; k < N; k++)
                            s = mod_sum(s, mod_prod(base[i*N+k], base[k*N+j], m), m);
                        sq[i*N+j] = s;
                    end
                end
                for (int i = 0; i < CELLS; i++) base[i] = sq[i];
            end
        end
        for (int i = 0; i < N; i++) begin
            b.index        = i[3:0];
            b.result_value = want_zero ? 62'd0 : pm_vec[i][61:0];
            b.last         = (i == N - 1);
            exp_beats.push_back(b);
        end
    endtask

    task automatic predict_item(t_in_item it, bit want_zero);
        logic [63:0] m;
        m = live_mod();
        case (it.cmd)
            CMD_MAT: begin
                if (it.row < N && it.col < N)
                    pm_mat[it.row*N + it.col] = {2'b00, it.value} % m;
            end
            CMD_VEC: begin
                if (it.col < N) pm_vec[it.col] = {2'b00, it.value} % m;
            end
            CMD_RUN: predict_power(it.exponent, want_zero);
            default: ;
        endcase
    endtask

    // hold start and the beat until the unit takes it
    task automatic send_item(t_in_item it, bit want_zero);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start  = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy);
        predict_item(it, want_zero);
    endtask

    task automatic write_modulus(logic [62:0] v);
        @(negedge i_clk);
        start = 1'b0;
        while (exp_beats.size() != 0 || busy) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        pm_mod      = {1'b0, v};
    endtask

    function automatic logic [61:0] rand_val();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[61:0];
    endfunction

    // scoring and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= WD_MAX) begin
                $display("%0t watchdog expired", $time);
                $display("modular_vector_matrix_power_unit_test NOT OK");
                $finish;
            end
        end
        if (i_rst_n && o_strobe) begin
            if (exp_beats.size() == 0) begin
                $display("%0t unexpected beat: got %p", $time, o_result);
                errors++;
            end else begin
                t_out_item e;
                e = exp_beats.pop_front();
                if (o_result.index !== e.index ||
                    o_result.result_value !== e.result_value ||
                    o_result.last !== e.last) begin
                    $display("%0t mismatch: expected idx %0d val %0d last %0b, got idx %0d val %0d last %0b",
                             $time, e.index, e.result_value, e.last,
                             o_result.index, o_result.result_value, o_result.last);
                    errors++;
                end
            end
        end
    end

    t_row rows[$];

    function automatic t_row mk(t_row_kind k, logic [1:0] c, int r, int cl,
                                logic [61:0] v, logic [62:0] e, bit z);
        t_row x;
        x.kind = k; x.cmd = c; x.row = r[3:0]; x.col = cl[3:0];
        x.value = v; x.exponent = e; x.want_zero = z;
        return x;
    endfunction

    initial begin
        t_in_item it;
        int       pick;
        logic [62:0] mods [4];
        idle_pct    = 0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        pm_mod      = {1'b0, MOD_RESET};
        for (int i = 0; i < CELLS; i++) pm_mat[i] = 64'd0;
        for (int i = 0; i < N; i++) pm_vec[i] = 64'd0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        rows.push_back(mk(ROW_ITEM, CMD_RUN, 0, 0, 0, 0, 1));   // cleared after reset
        rows.push_back(mk(ROW_ITEM, CMD_MAT, 0, 0, '1, 0, 0));
        rows.push_back(mk(ROW_ITEM, CMD_MAT, 10, 10, 5, 0, 0));
        rows.push_back(mk(ROW_ITEM, CMD_MAT, 0, 10, 3, 0, 0));
        rows.push_back(mk(ROW_ITEM, CMD_MAT, 11, 0, 9, 0, 0));  // row out of range
        rows.push_back(mk(ROW_ITEM, CMD_MAT, 0, 15, 9, 0, 0));  // col out of range
        rows.push_back(mk(ROW_ITEM, CMD_VEC, 0, 0, '1, 0, 0));
        rows.push_back(mk(ROW_ITEM, CMD_VEC, 15, 10, 7, 0, 0));
        rows.push_back(mk(ROW_ITEM, CMD_VEC, 0, 15, 8, 0, 0));  // position out of range
        rows.push_back(mk(ROW_ITEM, 2'd3, 15, 15, '1, '1, 0));  // unused command
        rows.push_back(mk(ROW_ITEM, CMD_RUN, 0, 0, 0, 0, 0));
        rows.push_back(mk(ROW_ITEM, CMD_RUN, 0, 0, 0, 1, 0));
        rows.push_back(mk(ROW_ITEM, CMD_RUN, 0, 0, 0, 5, 0));
        rows.push_back(mk(ROW_CFG,  0, 0, 0, 0, 0, 0));         // modulus zero
        rows.push_back(mk(ROW_ITEM, CMD_RUN, 0, 0, 0, 2, 1));
        rows.push_back(mk(ROW_ITEM, CMD_VEC, 0, 3, 123, 0, 0));
        rows.push_back(mk(ROW_ITEM, CMD_RUN, 0, 0, 0, 1, 1));
        rows.push_back(mk(ROW_CFG,  0, 0, 0, 0, 63'h4000_0000_0000_0000, 0));
        rows.push_back(mk(ROW_ITEM, CMD_MAT, 1, 1, '1, 0, 0));
        rows.push_back(mk(ROW_ITEM, CMD_VEC, 0, 1, '1, 0, 0));
        rows.push_back(mk(ROW_ITEM, CMD_RUN, 0, 0, 0, 3, 0));
        rows.push_back(mk(ROW_CFG,  0, 0, 0, 0, '1, 0));        // above two to the 62
        rows.push_back(mk(ROW_ITEM, CMD_MAT, 2, 2, '1, 0, 0));
        rows.push_back(mk(ROW_ITEM, CMD_RUN, 0, 0, 0, '1, 0));
        rows.push_back(mk(ROW_CFG,  0, 0, 0, 0, 63'd1, 0));
        rows.push_back(mk(ROW_ITEM, CMD_RUN, 0, 0, 0, 4, 1));
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_modulus(rows[i].exponent);
            end else begin
                it.cmd = rows[i].cmd; it.row = rows[i].row; it.col = rows[i].col;
                it.value = rows[i].value; it.exponent = rows[i].exponent;
                send_item(it, rows[i].want_zero);
            end
        end

        // random phases
        mods[0] = MOD_RESET;
        mods[1] = 63'($urandom_range(2, 1000));
        mods[2] = {1'b0, rand_val()};
        mods[3] = 63'h4000_0000_0000_0000 - 63'd1;
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 49 : (ph == 3) ? 31 : 0;
            write_modulus(mods[ph]);
            for (int n = 0; n < 76; n++) begin
                pick = $urandom_range(0, 99);
                it.value    = rand_val();
                it.exponent = 63'({$urandom(), $urandom()});
                it.row      = 4'($urandom_range(0, N - 1));
                it.col      = 4'($urandom_range(0, N - 1));
                if (pick < 4 || n == 75) begin
                    it.cmd      = CMD_RUN;
                    it.exponent = 63'($urandom_range(0, 7));
                end else if (pick < 54) begin
                    it.cmd = CMD_MAT;
                end else if (pick < 88) begin
                    it.cmd = CMD_VEC;
                end else begin
                    // noise: stray indexes or the unused command
                    it.cmd = 2'($urandom_range(0, 3));
                    if (it.cmd == CMD_RUN) it.cmd = 2'd3;
                    it.row = 4'($urandom_range(0, 15));
                    it.col = 4'($urandom_range(0, 15));
                end
                send_item(it, 0);
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        while (exp_beats.size() != 0 || busy) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0 && exp_beats.size() == 0) begin
            $display("modular_vector_matrix_power_unit_test OK");
        end else begin
            $display("modular_vector_matrix_power_unit_test NOT OK");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mvmp_pkg.sv
rtl/mvmp_cell.sv
rtl/mvmp_rem_unit.sv
rtl/modular_vector_matrix_power_unit.sv
verif/modular_vector_matrix_power_unit_test.sv
